>>> hw/rtl/abll_pkg.sv
// shared types and constants for the bitmap loss list
package abll_pkg;

  localparam int LOSS_DEPTH = 256;
  localparam int MAP_BITS   = 64;

  localparam int PTR_W  = $clog2(LOSS_DEPTH);
  localparam int CNT_W  = $clog2(LOSS_DEPTH + 1);
  localparam int POS_W  = $clog2(MAP_BITS + 1);
  localparam int IDX_W  = $clog2(MAP_BITS);

  localparam int SEQ_W  = 32;
  localparam int ID_W   = 32;
  localparam int TYPE_W = 16;
  localparam int TIDX_W = 32;
  localparam int LEN_W  = 7;
  localparam int BITS_W = 64;
  localparam int PEND_W = 9;
  localparam int DROP_W = 7;

  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  typedef struct packed {
    logic              command;
    logic [ID_W-1:0]   map_id;
    logic [SEQ_W-1:0]  start_seq;
    logic [LEN_W-1:0]  span_length;
    logic [LEN_W-1:0]  bitmap_length;
    logic [BITS_W-1:0] received_bits;
    logic [TYPE_W-1:0] item_type;
    logic [TIDX_W-1:0] table_index_in;
    logic              pop_head;
  } in_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  lost_seq;
    logic [ID_W-1:0]   lost_map_id;
    logic [TYPE_W-1:0] lost_type;
    logic [TIDX_W-1:0] lost_table_index;
    logic              loss_present;
    logic [PEND_W-1:0] pending_losses;
    logic [DROP_W-1:0] dropped_losses;
  } out_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [ID_W-1:0]   map_id;
    logic [TYPE_W-1:0] item_type;
    logic [TIDX_W-1:0] tag_index;
  } entry_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             full;
    logic             empty;
  } fifo_stat_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_RDWAIT = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

endpackage

>>> hw/rtl/ack_bitmap_loss_list.sv
// top level of the bitmap loss list
//
//  channel  ports                       handshake
//  input    start, busy, in_item        taken when start is high and busy is low
//  result   out_valid, out_item         one-cycle strobe, no back pressure
//
// an enqueue scans one map position per cycle, over the span (saturated
// to the map width); a read passes through a wait state for the
// registered memory read. busy stays high until the result is issued.
// reset clears the fifo pointers and count; entry storage is not cleared.
// the receiver cannot stall, so a result never waits.
module ack_bitmap_loss_list (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  abll_pkg::in_item_t  in_item,
  output logic                out_valid,
  output abll_pkg::out_item_t out_item
);
  import abll_pkg::*;

  fifo_stat_t stat;
  entry_t     rd_data;
  entry_t     wr_entry;
  out_item_t  result;
  logic       wr_en;
  logic       pop;
  logic       done;
  logic       out_valid_r;
  out_item_t  out_item_r;

  abll_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .stat     (stat),
    .rd_data  (rd_data),
    .busy     (busy),
    .wr_en    (wr_en),
    .wr_entry (wr_entry),
    .pop      (pop),
    .done     (done),
    .result   (result)
  );

  abll_loss_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_entry  (wr_entry),
    .pop       (pop),
    .rd_data_r (rd_data),
    .stat      (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> hw/rtl/abll_loss_fifo.sv
// loss fifo: entry memory with head, tail and fill count
module abll_loss_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  abll_pkg::entry_t    wr_entry,
  input  logic                pop,
  output abll_pkg::entry_t    rd_data_r,
  output abll_pkg::fifo_stat_t stat
);
  import abll_pkg::*;

  entry_t           mem [LOSS_DEPTH];
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (wr_en) begin
      tail_nxt  = (tail_r == PTR_W'(LOSS_DEPTH - 1)) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end else if (pop) begin
      head_nxt  = (head_r == PTR_W'(LOSS_DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= wr_entry;
    end
    rd_data_r <= mem[head_r];
  end

  assign stat.count = count_r;
  assign stat.full  = (count_r == CNT_W'(LOSS_DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

>>> hw/rtl/abll_seq.sv
// sequencer: walks the receive map one position a cycle and builds the result
module abll_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  abll_pkg::in_item_t   in_item,
  input  abll_pkg::fifo_stat_t stat,
  input  abll_pkg::entry_t     rd_data,
  output logic                 busy,
  output logic                 wr_en,
  output abll_pkg::entry_t     wr_entry,
  output logic                 pop,
  output logic                 done,
  output abll_pkg::out_item_t  result
);
  import abll_pkg::*;

  state_t              state_r, state_nxt;
  logic                cmd_r;
  logic                pop_r;
  logic [ID_W-1:0]     map_id_r;
  logic [TYPE_W-1:0]   item_type_r;
  logic [TIDX_W-1:0]   tidx_r;
  logic [SEQ_W-1:0]    seq_r;
  logic [POS_W-1:0]    pos_r;
  logic [POS_W-1:0]    span_r;
  logic [POS_W-1:0]    blen_r;
  logic [MAP_BITS-1:0] bits_r;
  logic [POS_W-1:0]    drop_r;

  logic [POS_W-1:0]    span_sat;
  logic [POS_W-1:0]    blen_sat;
  logic [POS_W-1:0]    pos_inc;
  logic                lost;
  logic                present;

  assign span_sat = (in_item.span_length > LEN_W'(MAP_BITS)) ? POS_W'(MAP_BITS)
                                                             : POS_W'(in_item.span_length);
  assign blen_sat = (in_item.bitmap_length > LEN_W'(MAP_BITS)) ? POS_W'(MAP_BITS)
                                                               : POS_W'(in_item.bitmap_length);
  assign pos_inc  = pos_r + 1'b1;
  assign lost     = !((pos_r < blen_r) && bits_r[pos_r[IDX_W-1:0]]);
  assign present  = !stat.empty;

  assign busy     = (state_r != S_IDLE);
  assign wr_en    = (state_r == S_SCAN) && lost && !stat.full;
  assign pop      = (state_r == S_FINISH) && (cmd_r == CMD_READ) && present && pop_r;
  assign done     = (state_r == S_FINISH);

  assign wr_entry.seq         = seq_r;
  assign wr_entry.map_id      = map_id_r;
  assign wr_entry.item_type   = item_type_r;
  assign wr_entry.tag_index   = tidx_r;

  always_comb begin
    result = '0;
    if (cmd_r == CMD_READ) begin
      if (present) begin
        result.lost_seq         = rd_data.seq;
        result.lost_map_id      = rd_data.map_id;
        result.lost_type        = rd_data.item_type;
        result.lost_table_index = rd_data.tag_index;
        result.loss_present     = 1'b1;
      end
      result.pending_losses = pop_r && present ? PEND_W'(stat.count - 1'b1)
                                               : PEND_W'(stat.count);
    end else begin
      result.pending_losses = PEND_W'(stat.count);
      result.dropped_losses = DROP_W'(drop_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_item.command == CMD_READ) begin
            state_nxt = S_RDWAIT;
          end else if (span_sat == '0) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (pos_inc == span_r) begin
          state_nxt = S_FINISH;
        end
      end
      S_RDWAIT: state_nxt = S_FINISH;
      S_FINISH: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      cmd_r       <= in_item.command;
      pop_r       <= in_item.pop_head;
      map_id_r    <= in_item.map_id;
      item_type_r <= in_item.item_type;
      tidx_r      <= in_item.table_index_in;
      seq_r       <= in_item.start_seq + 1'b1;
      pos_r       <= '0;
      span_r      <= span_sat;
      blen_r      <= blen_sat;
      bits_r      <= in_item.received_bits[MAP_BITS-1:0];
      drop_r      <= '0;
    end else if (state_r == S_SCAN) begin
      seq_r <= seq_r + 1'b1;
      pos_r <= pos_inc;
      if (lost && stat.full) begin
        drop_r <= drop_r + 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/abll_checker.sv
// port-level checker for the bitmap loss list and its bind
module abll_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input abll_pkg::out_item_t out_item
);
  import abll_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after transaction");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result issued while busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.loss_present |->
      out_item.lost_seq == '0 && out_item.lost_map_id == '0 &&
      out_item.lost_type == '0 && out_item.lost_table_index == '0)
    else $error("entry fields not zero without head entry");

  a_read_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.loss_present |->
      out_item.dropped_losses == '0 && out_item.pending_losses <= PEND_W'(LOSS_DEPTH))
    else $error("read result reports drops or bad count");

endmodule

bind ack_bitmap_loss_list abll_checker u_abll_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
